/* hw/rtl/ctsb_pkg.sv */
// ----------------------------------------------------------------------------
// ctsb_pkg - countdown timer slot bank shared definitions
// Transfer types, result kinds, command codes and defaults for the slot bank.
// ----------------------------------------------------------------------------
package ctsb_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_EXPIRY    = 8;   // expiry results reported per tick
	localparam int EXP_CNT_W     = 4;   // holds 0..MAX_EXPIRY
	localparam int COUNT_W       = 16;
	localparam int TIME_W        = 32;
	localparam int SLOT_FIELD_W  = 3;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [1:0] KIND_GRANTED = 2'd0;
	localparam logic [1:0] KIND_FULL    = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;
	localparam logic [1:0] KIND_IDLE    = 2'd3;

	typedef struct packed {
		logic               command;
		logic [COUNT_W-1:0] ticks;
	} item_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [TIME_W-1:0]       time_now;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic               busy;
		logic [COUNT_W-1:0] count;
	} slot_t;

endpackage

/* hw/rtl/countdown_timer_slot_bank_core.sv */
// ----------------------------------------------------------------------------
// countdown_timer_slot_bank_core - bank of one-shot countdown timers
// Slots live in a ring of cells that rotates past a single head update stage.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. command 0 claims the
//                    lowest free slot for item.ticks ticks (zero loads one);
//                    command 1 advances system time and counts down all slots.
//   result channel : result_valid / result_stall / result. A request gives one
//                    result (granted or full); a tick gives one result per
//                    expired slot in ascending order, up to MAX_EXPIRY, or one no-expiry result.
//                    result.last marks the final result of an item.
// Timing:
//   The ring rotates once per item, with one slot updated at the head each
//   cycle unless held. An item goes from idle through the rotation to a
//   done state that loads its last result; a stalled receiver holds the
//   rotation whenever an expiry result cannot be moved into the output
//   register. item_stall stays high for the whole of an item's processing.
// Reset:
//   arst_n clears system time, all busy flags and the output valid flag.
// ----------------------------------------------------------------------------
module countdown_timer_slot_bank_core #(
	parameter int NUM_SLOTS = ctsb_pkg::NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ctsb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ctsb_pkg::result_t result
);
	import ctsb_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic [SW-1:0]           step_q;
	logic                    cmd_q;
	logic [COUNT_W-1:0]      load_q;
	logic [TIME_W-1:0]       time_q;
	logic                    granted_q;
	logic [SLOT_FIELD_W-1:0] grant_slot_q;
	logic                    pend_valid_q;
	logic [SLOT_FIELD_W-1:0] pend_slot_q;
	logic [EXP_CNT_W-1:0]    n_q;
	logic                    out_valid_q;
	result_t                 out_q;

	slot_t chain [NUM_SLOTS];
	slot_t head;
	slot_t head_next;
	logic  shift;
	logic  out_free;
	logic  out_load;
	logic  expire;
	logic  report;
	logic  need_push;
	logic  grab;
	logic  step_end;
	logic [SW+SLOT_FIELD_W-1:0] step_wide;
	logic [SLOT_FIELD_W-1:0]    slot_lo;

	// ring of cells: each takes its upper neighbour, the top takes the head update
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		slot_t d;
		if (i == NUM_SLOTS - 1) begin : g_top
			assign d = head_next;
		end else begin : g_mid
			assign d = chain[i+1];
		end
		ctsb_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.d     (d),
			.q     (chain[i])
		);
	end

	assign head      = chain[0];
	assign out_free  = !out_valid_q || !result_stall;
	assign out_load  = (shift && need_push) || (state_q == ST_DONE && out_free);
	assign step_wide = {{SLOT_FIELD_W{1'b0}}, step_q};
	assign slot_lo   = step_wide[SLOT_FIELD_W-1:0];
	assign step_end  = (step_q == SW'(NUM_SLOTS - 1));

	always_comb begin
		head_next = head;
		expire    = 1'b0;
		report    = 1'b0;
		need_push = 1'b0;
		grab      = 1'b0;
		shift     = 1'b0;
		if (state_q == ST_RUN) begin
			if (cmd_q == CMD_REQUEST) begin
				grab = !head.busy && !granted_q;
				if (grab) begin
					head_next.busy  = 1'b1;
					head_next.count = load_q;
				end
				shift = 1'b1;
			end else begin
				// a busy slot never holds zero, so one means it runs out now
				expire    = head.busy && (head.count == COUNT_W'(1));
				report    = expire && (n_q < EXP_CNT_W'(MAX_EXPIRY));
				need_push = report && pend_valid_q;
				if (head.busy) begin
					head_next.count = head.count - COUNT_W'(1);
				end
				if (expire) begin
					head_next.busy = 1'b0;
				end
				shift = !need_push || out_free;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			time_q       <= '0;
			granted_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load || !result_stall) begin
				out_valid_q <= out_load;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.command == CMD_TICK) begin
							time_q <= time_q + TIME_W'(1);
						end
						granted_q    <= 1'b0;
						pend_valid_q <= 1'b0;
						n_q          <= '0;
						step_q       <= '0;
						state_q      <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (shift) begin
						if (grab) begin
							granted_q <= 1'b1;
						end
						if (report) begin
							pend_valid_q <= 1'b1;
							n_q          <= n_q + EXP_CNT_W'(1);
						end
						if (step_end) begin
							step_q  <= '0;
							state_q <= ST_DONE;
						end else begin
							step_q <= step_q + SW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side: no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			cmd_q  <= item.command;
			load_q <= (item.ticks == '0) ? COUNT_W'(1) : item.ticks;
		end
		if (state_q == ST_RUN && shift && grab) begin
			grant_slot_q <= slot_lo;
		end
		if (state_q == ST_RUN && shift && report) begin
			pend_slot_q <= slot_lo;
		end
		if (state_q == ST_RUN && shift && need_push) begin
			out_q.kind     <= KIND_EXPIRED;
			out_q.slot     <= pend_slot_q;
			out_q.time_now <= time_q;
			out_q.last     <= 1'b0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.time_now <= time_q;
			out_q.last     <= 1'b1;
			if (cmd_q == CMD_REQUEST) begin
				out_q.kind <= granted_q ? KIND_GRANTED : KIND_FULL;
				out_q.slot <= granted_q ? grant_slot_q : '0;
			end else begin
				out_q.kind <= pend_valid_q ? KIND_EXPIRED : KIND_IDLE;
				out_q.slot <= pend_valid_q ? pend_slot_q : '0;
			end
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* hw/rtl/ctsb_cell.sv */
// ----------------------------------------------------------------------------
// ctsb_cell - one timer slot of the rotating ring
// Holds a busy flag and a countdown; takes its neighbour's contents on shift.
// ----------------------------------------------------------------------------
module ctsb_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ctsb_pkg::slot_t d,
	output ctsb_pkg::slot_t q
);
	import ctsb_pkg::*;

	slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule
